// File: rtl/core/sidta_pkg.sv
// Shared types, character codes and the power-of-ten table for the
// signed integer to decimal ASCII converter. No dependencies.
package sidta_pkg;

   localparam int          NUM_PLACES  = 10;
   localparam int          PLACE_W     = 4;
   localparam int          MULT_W      = 34;   // 9 * 10^9 needs 34 bits
   localparam logic [3:0]  TOP_PLACE   = 4'd9;
   localparam logic [3:0]  LAST_PLACE  = 4'd0;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [7:0]  CHAR_MINUS  = 8'h2D;

   typedef struct packed {
      logic        negative;
      logic [31:0] mag;
   } work_item_type;

   typedef struct packed {
      logic          valid;
      work_item_type item;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGIT
   } back_state_type;

   function automatic logic [MULT_W-1:0] pow10(input logic [PLACE_W-1:0] place);
      logic [MULT_W-1:0] p;
      unique case (place)
         4'd0:    p = 34'd1;
         4'd1:    p = 34'd10;
         4'd2:    p = 34'd100;
         4'd3:    p = 34'd1000;
         4'd4:    p = 34'd10000;
         4'd5:    p = 34'd100000;
         4'd6:    p = 34'd1000000;
         4'd7:    p = 34'd10000000;
         4'd8:    p = 34'd100000000;
         4'd9:    p = 34'd1000000000;
         default: p = 34'd0;
      endcase
      return p;
   endfunction

endpackage

// File: rtl/core/sidta_front.sv
// Front end: takes input beats, splits them into sign and magnitude.
// Depends on sidta_pkg; feeds sidta_queue.
module sidta_front
   import sidta_pkg::*;
(
   input  logic          req_push,
   input  logic [31:0]   req_value,
   output logic          req_full,
   input  logic          q_full,
   output logic          q_push,
   output work_item_type q_item
);

   always_comb begin
      req_full        = q_full;
      q_push          = req_push && !q_full;
      q_item.negative = req_value[31];
      // most negative value wraps to 2^31, which fits the unsigned magnitude
      q_item.mag      = req_value[31] ? (32'd0 - req_value) : req_value;
   end

endmodule

// File: rtl/core/sidta_queue.sv
// Short FIFO of classified items between front and back.
// Depends on sidta_pkg.
module sidta_queue
   import sidta_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  work_item_type push_item,
   output logic          full,
   input  logic          pop,
   output queue_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   work_item_type    slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full       = (count_ff == CNT_FULL);
      head.valid = (count_ff != '0);
      head.item  = slots_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head.valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/sidta_back.sv
// Back end: walks the ten decimal places high to low, one per cycle unless a printed
// digit waits for the result register, and drives that register. Depends on sidta_pkg.
module sidta_back
   import sidta_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           q_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output logic [7:0]     rsp_ascii_char,
   output logic           rsp_last_char
);

   back_state_type       state_ff, state_in;
   logic [31:0]          mag_ff, mag_in;
   logic [PLACE_W-1:0]   place_ff, place_in;
   logic                 seen_ff, seen_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;

   logic [MULT_W-1:0]    mult [NUM_PLACES];
   logic [PLACE_W-1:0]   digit;
   logic                 out_free, emit;

   // digit = largest d with d * 10^place <= mag
   always_comb begin
      digit = '0;
      for (int d = 0; d < NUM_PLACES; d++) begin
         mult[d] = MULT_W'(pow10(place_ff) * MULT_W'(d));
      end
      for (int d = 1; d < NUM_PLACES; d++) begin
         if ({2'b00, mag_ff} >= mult[d]) begin
            digit = PLACE_W'(d);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      place_in     = place_ff;
      seen_in      = seen_ff;
      out_free     = !out_valid_ff || rsp_pop;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      // leading zeros are skipped, but the ones place always prints
      emit         = seen_ff || (digit != '0) || (place_ff == LAST_PLACE);

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               q_pop    = 1'b1;
               mag_in   = head.item.mag;
               place_in = TOP_PLACE;
               seen_in  = 1'b0;
               state_in = head.item.negative ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (!emit || out_free) begin
               if (emit) begin
                  out_valid_in = 1'b1;
                  out_char_in  = CHAR_ZERO + {4'b0000, digit};
                  out_last_in  = (place_ff == LAST_PLACE);
                  seen_in      = 1'b1;
               end
               mag_in = mag_ff - mult[digit][31:0];
               if (place_ff == LAST_PLACE) begin
                  state_in = ST_IDLE;
               end else begin
                  place_in = place_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      place_ff    <= place_in;
      seen_ff     <= seen_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_ascii_char = out_char_ff;
   assign rsp_last_char  = out_last_ff;

endmodule

// File: rtl/core/signed_int_to_decimal_ascii_top.sv
// Signed 32-bit integer to decimal ASCII text, one character per result beat.
// With the sequencer idle, the first character of a negative or ten-digit value passes the
// queue, the pop and the sign or top place; skipped leading zero places come before it.
// The sequencer takes a new item only once the last is done: it takes the item, adds a
// sign if negative, then ten places one per cycle unless a digit waits for the result.
// Reset: synchronous, active high; clears the queue and the sequencer, drops any result.
// Depends on sidta_pkg, sidta_front, sidta_queue, sidta_back.
module signed_int_to_decimal_ascii_top
   import sidta_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [31:0] req_value,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_ascii_char,
   output logic        rsp_last_char
);

   logic           q_full, q_push, q_pop;
   work_item_type  q_item;
   queue_head_type q_head;

   sidta_front u_front (
      .req_push  (req_push),
      .req_value (req_value),
      .req_full  (req_full),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   sidta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head)
   );

   sidta_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

// File: bench/signed_int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 1ps
// Testbench for signed_int_to_decimal_ascii_top: sends signed integers, predicts the
// decimal text of each one and checks every character beat in order.
// Depends on sidta_pkg and the RTL of signed_int_to_decimal_ascii_top.
module signed_int_to_decimal_ascii_top_tb
   import sidta_pkg::*;
;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_LEN    = 300;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [31:0] req_value = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_ascii_char;
   logic        rsp_last_char;

   text_beat_type expected_text[$];
   int          errors = 0;
   int          cycle_count = 0;
   bit          send_idle_on = 1'b0;
   bit          pop_idle_on = 1'b0;
   bit          hold_req = 1'b0;
   int          hold_count = 0;
   int          pop_stall_left = 0;

   signed_int_to_decimal_ascii_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_value      (req_value),
      .req_full       (req_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("status: fail");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] ten_to(input int n);
      logic [31:0] p;
      p = 32'd1;
      repeat (n) p = p * 32'd10;
      return p;
   endfunction

   function automatic logic [31:0] pick_value();
      int          r;
      int          n;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mag;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         v = $urandom();
      end else if (r < 60) begin
         // pick a digit count first so short numbers show up often
         n = $urandom_range(1, 10);
         lo = (n == 1) ? 32'd0 : ten_to(n - 1);
         hi = (n == 10) ? 32'h7FFF_FFFF : ten_to(n) - 32'd1;
         mag = $urandom_range(hi, lo);
         v = $urandom_range(0, 1) ? -mag : mag;
      end else if (r < 80) begin
         mag = $urandom_range(0, 99);
         v = $urandom_range(0, 1) ? -mag : mag;
      end else if (r < 90) begin
         // power of ten, or one off it
         mag = ten_to($urandom_range(0, 9)) + 32'($urandom_range(0, 2)) - 32'd1;
         v = $urandom_range(0, 1) ? -mag : mag;
      end else begin
         case ($urandom_range(0, 3))
            0:       v = 32'h0000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h8000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end
      return v;
   endfunction

   // expected decimal text of one value, sign first, digits most significant first
   function automatic void add_expected_text(input logic [31:0] v);
      logic [31:0]   mag;
      logic [7:0]    digit[10];
      int            n;
      text_beat_type b;
      mag = v[31] ? (~v + 32'd1) : v;
      n = 0;
      do begin
         digit[n] = 8'(mag % 32'd10);
         mag = mag / 32'd10;
         n++;
      end while (mag != 32'd0);
      if (v[31]) begin
         b.ch = CHAR_MINUS;
         b.last = 1'b0;
         expected_text.push_back(b);
      end
      for (int i = n - 1; i >= 0; i--) begin
         b.ch = CHAR_ZERO + digit[i];
         b.last = (i == 0);
         expected_text.push_back(b);
      end
   endfunction

   // leaves req_push high after the beat so back-to-back items need no bubble
   task automatic send_value(input logic [31:0] v);
      int gap;
      gap = send_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_full);
      add_expected_text(v);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_text.size() != 0);
   endtask

   // result side: check the beat taken at this edge, then choose the next pop
   always @(posedge clock) begin
      logic          pop_next;
      text_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_text.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got char %h last %b",
                     $time, rsp_ascii_char, rsp_last_char);
         end else begin
            want = expected_text.pop_front();
            if (rsp_ascii_char !== want.ch) begin
               errors++;
               $display("%0t: ascii_char mismatch, expected %h got %h",
                        $time, want.ch, rsp_ascii_char);
            end
            if (rsp_last_char !== want.last) begin
               errors++;
               $display("%0t: last_char mismatch, expected %b got %b",
                        $time, want.last, rsp_last_char);
            end
         end
      end
      pop_next = 1'b1;
      if (reset) begin
         pop_next = 1'b0;
      end else if (hold_req && hold_count < HOLD_LEN) begin
         pop_next = 1'b0;
         hold_count++;
      end else if (pop_stall_left > 0) begin
         pop_next = 1'b0;
         pop_stall_left--;
      end else if (pop_idle_on && $urandom_range(0, 99) < 30) begin
         pop_stall_left = pick_gap();
         if (pop_stall_left > 0) begin
            pop_next = 1'b0;
            pop_stall_left--;
         end
      end
      rsp_pop <= pop_next;
   end

   task automatic test_directed();
      logic [31:0] vals[$];
      vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd9, -32'd10, 32'd99,
               32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
               32'd999999999, -32'd1000000000, 32'd123456789, -32'd123456789,
               32'd1999999999, 32'hAAAA_AAAA, 32'h5555_5555};
      send_idle_on = 1'b0;
      pop_idle_on = 1'b0;
      foreach (vals[i]) send_value(vals[i]);
      wait_drained();
   endtask

   // every digit count, both signs, streamed with no gaps on either side
   task automatic test_digit_lengths();
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mag;
      send_idle_on = 1'b0;
      pop_idle_on = 1'b0;
      for (int n = 1; n <= 10; n++) begin
         lo = (n == 1) ? 32'd0 : ten_to(n - 1);
         hi = (n == 10) ? 32'h7FFF_FFFF : ten_to(n) - 32'd1;
         for (int k = 0; k < 6; k++) begin
            mag = $urandom_range(hi, lo);
            send_value(k[0] ? -mag : mag);
         end
      end
      wait_drained();
   endtask

   // receiver stalls long enough for the block to fill and push back on input
   task automatic test_back_pressure();
      send_idle_on = 1'b0;
      pop_idle_on = 1'b0;
      hold_req = 1'b1;
      repeat (10) send_value(pick_value());
      hold_req = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_values();
      for (int blk = 0; blk < 6; blk++) begin
         send_idle_on = (blk == 0) ? 1'b0 : (blk == 1) ? 1'b1 : 1'($urandom_range(0, 1));
         pop_idle_on = (blk == 0) ? 1'b0 : (blk == 1) ? 1'b1 : 1'($urandom_range(0, 1));
         repeat (50) send_value(pick_value());
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_digit_lengths();
      test_back_pressure();
      test_random_values();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_text.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/sidta_pkg.sv
rtl/core/sidta_front.sv
rtl/core/sidta_queue.sv
rtl/core/sidta_back.sv
rtl/core/signed_int_to_decimal_ascii_top.sv
bench/signed_int_to_decimal_ascii_top_tb.sv
